// File: rtl/core/assert_macros.svh
// assertion macros for the checker file
// each expects clk and rst to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/nmcell_pkg.sv
// shared constants and types for the navmesh cell test and height core
// no dependencies
`default_nettype none

package nmcell_pkg;

  localparam int REG_W          = 48;
  localparam int NBR_W          = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int EDGE_W         = 2;
  localparam int STATUS_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOURS = 2'd3;

  localparam logic [EDGE_W-1:0] EDGE_AB   = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_BC   = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_CA   = 2'd2;
  localparam logic [EDGE_W-1:0] EDGE_NONE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_VALID = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEGEN = 2'd2;

  typedef struct packed {
    logic              in_cell;
    logic [EDGE_W-1:0] exit_code;
    logic [NBR_W-1:0]  nidx;
  } edge_res_t;

endpackage

`default_nettype wire

// File: rtl/core/navmesh_cell_test_and_height_core.sv
// Navmesh cell point-in-triangle test and plane height at a query position.
// A query passes through COORD_BITS + 8 register stages, and one query is taken
// every cycle while the output is not stalled. Most of the depth is the height divider,
// a restoring divider that settles one quotient bit per pipeline stage, behind
// the edge products, the plane normal and the plane products. Stalls collapse
// bubbles stage by stage, so new words are accepted while a result waits until the pipeline is full.
// Depends on nmcell_pkg.
`default_nettype none

module navmesh_cell_test_and_height_core #(
  parameter int COORD_BITS = nmcell_pkg::COORD_BITS_DEF,
  localparam int DATA_W =
    (3 * COORD_BITS > nmcell_pkg::REG_W) ? 3 * COORD_BITS : nmcell_pkg::REG_W
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [nmcell_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [DATA_W-1:0]                   cfg_wdata,
  input  logic                                query_valid,
  output logic                                query_ready,
  input  logic signed [COORD_BITS-1:0]        pos_x,
  input  logic signed [COORD_BITS-1:0]        pos_z,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                inside_res,
  output logic [nmcell_pkg::EDGE_W-1:0]       exit_edge,
  output logic signed [nmcell_pkg::NBR_W-1:0] neighbour_index,
  output logic signed [COORD_BITS-1:0]        height,
  output logic [nmcell_pkg::STATUS_W-1:0]     height_status
);

  import nmcell_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * C + 2;
  localparam int NW = 2 * C + 3;
  localparam int MW = 3 * C + 4;
  localparam int TW = 3 * C + 8;
  localparam int NS = C + 8;

  // configuration
  logic [3*C-1:0]   va, vb, vc;
  logic [REG_W-1:0] nbrs;

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= '0;
      vb   <= '0;
      vc   <= '0;
      nbrs <= '1;
    end else if (cfg_wen) begin
      case (cfg_idx)
        REG_VERTEX_A:   va   <= cfg_wdata[3*C-1:0];
        REG_VERTEX_B:   vb   <= cfg_wdata[3*C-1:0];
        REG_VERTEX_C:   vc   <= cfg_wdata[3*C-1:0];
        REG_NEIGHBOURS: nbrs <= cfg_wdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [C-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;

  assign ax = va[C-1:0];
  assign ay = va[2*C-1:C];
  assign az = va[3*C-1:2*C];
  assign bx = vb[C-1:0];
  assign by = vb[2*C-1:C];
  assign bz = vb[3*C-1:2*C];
  assign cx = vc[C-1:0];
  assign cy = vc[2*C-1:C];
  assign cz = vc[3*C-1:2*C];

  // pipeline control
  logic [NS-1:0] vld;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = result_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= query_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign query_ready  = en[0];
  assign result_valid = vld[NS-1];

  // stage 0: differences
  logic signed [DW-1:0] s0_ex [3];
  logic signed [DW-1:0] s0_ez [3];
  logic signed [DW-1:0] s0_qx [3];
  logic signed [DW-1:0] s0_qz [3];
  logic signed [DW-1:0] s0_e1x, s0_e1y, s0_e1z, s0_e2x, s0_e2y, s0_e2z;
  logic signed [C-1:0]  s0_ay;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_ex[0] <= DW'(bx) - DW'(ax);
      s0_ez[0] <= DW'(bz) - DW'(az);
      s0_ex[1] <= DW'(cx) - DW'(bx);
      s0_ez[1] <= DW'(cz) - DW'(bz);
      s0_ex[2] <= DW'(ax) - DW'(cx);
      s0_ez[2] <= DW'(az) - DW'(cz);
      s0_qx[0] <= DW'(pos_x) - DW'(ax);
      s0_qz[0] <= DW'(pos_z) - DW'(az);
      s0_qx[1] <= DW'(pos_x) - DW'(bx);
      s0_qz[1] <= DW'(pos_z) - DW'(bz);
      s0_qx[2] <= DW'(pos_x) - DW'(cx);
      s0_qz[2] <= DW'(pos_z) - DW'(cz);
      s0_e1x   <= DW'(bx) - DW'(ax);
      s0_e1y   <= DW'(by) - DW'(ay);
      s0_e1z   <= DW'(bz) - DW'(az);
      s0_e2x   <= DW'(cx) - DW'(ax);
      s0_e2y   <= DW'(cy) - DW'(ay);
      s0_e2z   <= DW'(cz) - DW'(az);
      s0_ay    <= ay;
    end
  end

  // stage 1: edge and normal products
  logic signed [PW-1:0] s1_ma [3];
  logic signed [PW-1:0] s1_mb [3];
  logic signed [PW-1:0] s1_pyz, s1_pzy, s1_pzx, s1_pxz, s1_pxy, s1_pyx;
  logic signed [C-1:0]  s1_ay;
  logic signed [DW-1:0] s1_qx, s1_qz;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_ma[i] <= PW'(s0_ez[i]) * PW'(s0_qx[i]);
        s1_mb[i] <= PW'(s0_ex[i]) * PW'(s0_qz[i]);
      end
      s1_pyz <= PW'(s0_e1y) * PW'(s0_e2z);
      s1_pzy <= PW'(s0_e1z) * PW'(s0_e2y);
      s1_pzx <= PW'(s0_e1z) * PW'(s0_e2x);
      s1_pxz <= PW'(s0_e1x) * PW'(s0_e2z);
      s1_pxy <= PW'(s0_e1x) * PW'(s0_e2y);
      s1_pyx <= PW'(s0_e1y) * PW'(s0_e2x);
      s1_ay  <= s0_ay;
      s1_qx  <= s0_qx[0];
      s1_qz  <= s0_qz[0];
    end
  end

  // stage 2: edge tests and plane normal
  logic signed [NW-1:0] dot [3];
  logic [2:0]           outside;
  edge_res_t            er_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot[i]     = NW'(s1_mb[i]) - NW'(s1_ma[i]);
      outside[i] = !dot[i][NW-1] && (|dot[i]);
    end
    if (outside[0]) begin
      er_next = '{in_cell: 1'b0, exit_code: EDGE_AB, nidx: nbrs[NBR_W-1:0]};
    end else if (outside[1]) begin
      er_next = '{in_cell: 1'b0, exit_code: EDGE_BC, nidx: nbrs[2*NBR_W-1:NBR_W]};
    end else if (outside[2]) begin
      er_next = '{in_cell: 1'b0, exit_code: EDGE_CA, nidx: nbrs[3*NBR_W-1:2*NBR_W]};
    end else begin
      er_next = '{in_cell: 1'b1, exit_code: EDGE_NONE, nidx: {NBR_W{1'b1}}};
    end
  end

  edge_res_t            er [NS-2];
  logic signed [NW-1:0] s2_na, s2_nb, s2_nc;
  logic signed [C-1:0]  s2_ay;
  logic signed [DW-1:0] s2_qx, s2_qz;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      er[0] <= er_next;
      s2_na <= NW'(s1_pyz) - NW'(s1_pzy);
      s2_nb <= NW'(s1_pzx) - NW'(s1_pxz);
      s2_nc <= NW'(s1_pxy) - NW'(s1_pyx);
      s2_ay <= s1_ay;
      s2_qx <= s1_qx;
      s2_qz <= s1_qz;
    end
  end

  for (genvar g = 1; g < NS - 2; g++) begin : g_er
    always_ff @(posedge clk) begin
      if (en[g+2]) begin
        er[g] <= er[g-1];
      end
    end
  end

  // stage 3: normal with positive y
  logic                 dg [NS-4];
  logic signed [NW-1:0] s3_na, s3_nb, s3_nc;
  logic signed [C-1:0]  s3_ay;
  logic signed [DW-1:0] s3_qx, s3_qz;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dg[0] <= (s2_nb == '0);
      s3_na <= s2_nb[NW-1] ? -s2_na : s2_na;
      s3_nb <= s2_nb[NW-1] ? -s2_nb : s2_nb;
      s3_nc <= s2_nb[NW-1] ? -s2_nc : s2_nc;
      s3_ay <= s2_ay;
      s3_qx <= s2_qx;
      s3_qz <= s2_qz;
    end
  end

  for (genvar g = 1; g < NS - 4; g++) begin : g_dg
    always_ff @(posedge clk) begin
      if (en[g+3]) begin
        dg[g] <= dg[g-1];
      end
    end
  end

  // stage 4: plane products
  logic signed [MW-1:0] s4_pa, s4_pb, s4_pc;
  logic signed [NW-1:0] s4_nb;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_pa <= MW'(s3_ay) * MW'(s3_nb);
      s4_pb <= MW'(s3_na) * MW'(s3_qx);
      s4_pc <= MW'(s3_nc) * MW'(s3_qz);
      s4_nb <= s3_nb;
    end
  end

  // stage 5: doubled numerator with half-step offset
  logic signed [TW-1:0] s5_t;
  logic signed [NW-1:0] s5_nb;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_t  <= ((TW'(s4_pa) - TW'(s4_pb) - TW'(s4_pc)) <<< 1) + TW'(s4_nb);
      s5_nb <= s4_nb;
    end
  end

  // stage 6: magnitude, divisor and range check
  logic          t_neg;
  logic [TW-1:0] t_mag;
  logic [NW-1:0] dvs;
  logic          presat;

  always_comb begin
    t_neg  = s5_t[TW-1];
    t_mag  = t_neg ? TW'(-s5_t) : TW'(s5_t);
    dvs    = {s5_nb[NW-2:0], 1'b0};
    presat = t_mag >= (TW'(dvs) << C);
  end

  logic [TW-1:0] dv_r   [C+1];
  logic [C-1:0]  dv_q   [C+1];
  logic [NW-1:0] dv_d   [C+1];
  logic          dv_neg [C+1];
  logic          dv_sat [C+1];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      dv_r[0]   <= t_mag;
      dv_q[0]   <= '0;
      dv_d[0]   <= dvs;
      dv_neg[0] <= t_neg;
      dv_sat[0] <= presat;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < C; j++) begin : g_div
    localparam int K = C - 1 - j;
    logic [TW-1:0] sub;
    logic          ge;

    assign sub = TW'(dv_d[j]) << K;
    assign ge  = dv_r[j] >= sub;

    always_ff @(posedge clk) begin
      if (en[7+j]) begin
        dv_r[j+1]   <= ge ? dv_r[j] - sub : dv_r[j];
        dv_q[j+1]   <= dv_q[j] | (C'(ge) << K);
        dv_d[j+1]   <= dv_d[j];
        dv_neg[j+1] <= dv_neg[j];
        dv_sat[j+1] <= dv_sat[j];
      end
    end
  end

  // output stage: rounding, saturation and degenerate-plane status
  logic [C:0]          qf;
  logic [C:0]          lim;
  logic [C:0]          qn;
  logic                sat;
  logic signed [C-1:0] h_next;
  logic [STATUS_W-1:0] st_next;

  always_comb begin
    qf  = (C+1)'(dv_q[C]) + (C+1)'(dv_neg[C] && (|dv_r[C]));
    lim = dv_neg[C] ? ((C+1)'(1) << (C - 1)) : (((C+1)'(1) << (C - 1)) - (C+1)'(1));
    qn  = (C+1)'(0) - qf;
    sat = dv_sat[C] || (qf > lim);
    if (dg[NS-5]) begin
      h_next  = '0;
      st_next = ST_DEGEN;
    end else if (sat) begin
      h_next  = dv_neg[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
      st_next = ST_SAT;
    end else begin
      h_next  = dv_neg[C] ? qn[C-1:0] : qf[C-1:0];
      st_next = ST_VALID;
    end
  end

  logic signed [C-1:0] res_height;
  logic [STATUS_W-1:0] res_status;

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      res_height <= h_next;
      res_status <= st_next;
    end
  end

  assign inside_res      = er[NS-3].in_cell;
  assign exit_edge       = er[NS-3].exit_code;
  assign neighbour_index = er[NS-3].nidx;
  assign height          = res_height;
  assign height_status   = res_status;

endmodule

`default_nettype wire

// File: rtl/core/nmcell_chk.sv
// port-level checks for the navmesh cell test and height core, with its bind
// depends on nmcell_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module nmcell_chk #(
  parameter int COORD_BITS = nmcell_pkg::COORD_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                result_valid,
  input logic                                result_ready,
  input logic                                inside_res,
  input logic [nmcell_pkg::EDGE_W-1:0]       exit_edge,
  input logic signed [nmcell_pkg::NBR_W-1:0] neighbour_index,
  input logic signed [COORD_BITS-1:0]        height,
  input logic [nmcell_pkg::STATUS_W-1:0]     height_status
);

  import nmcell_pkg::*;

  localparam logic [COORD_BITS-1:0] H_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] H_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  `NMC_ASSERT_NEXT(a_word_held, result_valid && !result_ready, result_valid && $stable(height) && $stable(exit_edge), "result word dropped while stalled")
  `NMC_ASSERT_NOW(a_inside_code, result_valid, inside_res == (exit_edge == EDGE_NONE), "inside flag and exit edge disagree")
  `NMC_ASSERT_NOW(a_inside_nbr, result_valid && inside_res, neighbour_index == {NBR_W{1'b1}}, "neighbour given for inside position")
  `NMC_ASSERT_NOW(a_degen_zero, result_valid && (height_status == ST_DEGEN), height == '0, "degenerate plane with nonzero height")
  `NMC_ASSERT_NOW(a_sat_limit, result_valid && (height_status == ST_SAT), (height == H_MAX) || (height == H_MIN), "saturated height not at a limit")

endmodule

bind navmesh_cell_test_and_height_core nmcell_chk #(.COORD_BITS(COORD_BITS)) u_nmcell_chk (.*);

`default_nettype wire
